>>> src/slime_chunk_check_defines.svh
// ----------------------------------------------------------------------------
// Slime chunk check: assertion macros
// Shared assertion wrappers; defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef SLIME_CHUNK_CHECK_DEFINES_SVH
`define SLIME_CHUNK_CHECK_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every rising edge, ignored while reset is asserted.
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every rising edge, reset included.
`define SCC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCC_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

>>> src/scc_pkg.sv
// ----------------------------------------------------------------------------
// Slime chunk check package
// Constants, types and generator step helpers shared by the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  // Seed mixing constants.
  localparam logic [31:0] XX_MUL     = 32'd4987142;
  localparam logic [31:0] X_MUL      = 32'd5947611;
  localparam logic [22:0] ZZ_MUL     = 23'd4392871;
  localparam logic [31:0] Z_MUL      = 32'd389711;
  localparam logic [47:0] CHUNK_XOR  = 48'd987234911;

  // 48-bit linear congruential generator.
  localparam logic [47:0] LCG_MUL    = 48'h0005_DEEC_E66D;
  localparam logic [23:0] LCG_MUL_LO = 24'hECE66D;
  localparam logic [10:0] LCG_MUL_HI = 11'h5DE;
  localparam logic [47:0] LCG_ADD    = 48'hB;

  // Draws at or above this limit are rejected and drawn again.
  localparam logic [30:0] DRAW_LIMIT = 31'd2147483640;

  // Reciprocal of ten for a 31-bit dividend: q = (n * RECIP10) >> RECIP10_SH.
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP10_SH = 35;

  // Partial products of one generator step, split at bit 24.
  typedef struct packed {
    logic [47:0] p0;  // low half times low multiplier half
    logic [23:0] p1;  // high half times low multiplier half, low bits
    logic [23:0] p2;  // low half times high multiplier half, low bits
  } lcg_pp_t;

  // Status of the redraw unit towards the top level.
  typedef struct packed {
    logic busy;     // holding an item whose draw was rejected
    logic add_ph;   // in the summing half of a redraw step
  } scc_rd_stat_t;

  // First half of a generator step: the three partial products.
  function automatic lcg_pp_t lcg_pp(input logic [47:0] st);
    lcg_pp_t pp;
    pp.p0 = {24'b0, st[23:0]} * {24'b0, LCG_MUL_LO};
    pp.p1 = st[47:24] * LCG_MUL_LO;
    pp.p2 = st[23:0] * {13'b0, LCG_MUL_HI};
    return pp;
  endfunction

  // Second half of a generator step: state * multiplier + addend, 48-bit wrap.
  function automatic logic [47:0] lcg_sum(input lcg_pp_t pp);
    logic [23:0] mid;
    mid = pp.p1 + pp.p2;
    return pp.p0 + {mid, 24'b0} + LCG_ADD;
  endfunction

endpackage

`default_nettype wire

>>> src/scc_redraw.sv
// ----------------------------------------------------------------------------
// Slime chunk check: draw check and redraw unit
// Holds one generator state, accepts its draw or steps it again until the
// draw falls below the limit. Each redraw forms partial products, then sums.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_redraw
  import scc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [47:0]  in_state,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [30:0]       out_draw,
  output scc_rd_stat_t      stat
);

  localparam logic PH_MUL = 1'b0;
  localparam logic PH_ADD = 1'b1;

  logic        v_r;
  logic        ph_r;
  logic [47:0] st_r;
  lcg_pp_t     pp_r;
  logic [30:0] draw;
  logic        reject;

  // The draw is the top 31 bits of the current state.
  assign draw      = st_r[47:17];
  assign reject    = (draw >= DRAW_LIMIT);
  assign out_valid = v_r && !reject;
  assign out_draw  = draw;
  assign in_ready  = !v_r || (!reject && out_ready);

  assign stat.busy   = v_r && reject;
  assign stat.add_ph = (ph_r == PH_ADD);

  // Valid and phase control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      ph_r <= PH_MUL;
    end else begin
      if (in_ready) begin
        v_r <= in_valid;
      end
      if (v_r && reject) begin
        ph_r <= (ph_r == PH_MUL) ? PH_ADD : PH_MUL;
      end
    end
  end

  // State load and generator step (products, then sum) for a rejected draw.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      st_r <= in_state;
    end else if (v_r && reject) begin
      unique case (ph_r)
        PH_MUL: begin
          pp_r <= lcg_pp(st_r);
        end
        PH_ADD: begin
          st_r <= lcg_sum(pp_r);
        end
        default: begin
          st_r <= st_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/slime_chunk_check.sv
// ----------------------------------------------------------------------------
// Slime chunk check
// Decides per chunk coordinate pair whether the chunk is a slime chunk.
// ----------------------------------------------------------------------------
// The block takes one request (chunk_x, chunk_z) per clock when nothing stalls
// and returns one is_slime flag per request, in order. The nine-stage pipeline
// mixes the chunk seed over four stages, runs the first generator step over
// two, checks the draw in the redraw unit and reduces it modulo ten over two.
// A draw at or above 2147483640 (about four in a thousand million) is stepped
// again in the redraw unit, which holds the pipeline during each extra step.
// The user must write the world seed over the cfg port only while no request
// is in flight; the block itself does not enforce this.
`default_nettype none
`include "slime_chunk_check_defines.svh"

module slime_chunk_check
  import scc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: world seed.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data,
  // Requests.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] chunk_x, [63:32] chunk_z
  // Results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [0] is_slime, [7:1] zero
);

  logic [63:0] world_seed_r;

  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s8_v_r, out_v_r;
  logic        rdy2, rdy3, rdy4, rdy5, rdy6, rdy8, rdy9;

  logic [31:0] s1_xx_r, s1_zz_r, s1_xt_r, s1_zt_r;
  logic [31:0] s2_xxk_r, s2_xt_r, s2_zt_r;
  logic [47:0] s2_zzk_r;
  logic [47:0] s3_sa_r, s3_sb_r;
  logic [47:0] s4_st_r;
  lcg_pp_t     s5_pp_r;
  logic [47:0] s6_st_r;
  logic [30:0] s8_draw_r;
  logic [62:0] s8_prod_r;
  logic        out_flag_r;

  logic [31:0] chunk_x, chunk_z;
  logic [47:0] zz_ext;
  logic [47:0] zz_fix;
  logic        rd_in_ready;
  logic        rd_out_valid;
  logic [30:0] rd_draw;
  scc_rd_stat_t rd_stat;
  logic [27:0] s9_q;
  logic [30:0] s9_q10;

  assign chunk_x = in_tdata[31:0];
  assign chunk_z = in_tdata[63:32];

  // World seed register; always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_seed_r <= 64'd0;
    end else if (cfg_valid) begin
      world_seed_r <= cfg_data;
    end
  end

  // Stage ready chain: a stage moves when it is empty or its item moves on.
  assign rdy9      = !out_v_r || out_tready;
  assign rdy8      = !s8_v_r || rdy9;
  assign rdy6      = !s6_v_r || rd_in_ready;
  assign rdy5      = !s5_v_r || rdy6;
  assign rdy4      = !s4_v_r || rdy5;
  assign rdy3      = !s3_v_r || rdy4;
  assign rdy2      = !s2_v_r || rdy3;
  assign in_tready = !s1_v_r || rdy2;

  // Valid bits travelling with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) s1_v_r  <= in_tvalid;
      if (rdy2)      s2_v_r  <= s1_v_r;
      if (rdy3)      s3_v_r  <= s2_v_r;
      if (rdy4)      s4_v_r  <= s3_v_r;
      if (rdy5)      s5_v_r  <= s4_v_r;
      if (rdy6)      s6_v_r  <= s5_v_r;
      if (rdy8)      s8_v_r  <= rd_out_valid;
      if (rdy9)      out_v_r <= s8_v_r;
    end
  end

  // Stage 1: the four 32-bit wrapping products of the coordinates.
  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_xx_r <= chunk_x * chunk_x;
      s1_zz_r <= chunk_z * chunk_z;
      s1_xt_r <= chunk_x * X_MUL;
      s1_zt_r <= chunk_z * Z_MUL;
    end
  end

  // Stage 2: x*x scaled at 32 bits; z*z sign-extended and scaled at 48 bits.
  // Only the low 48 bits of the chunk seed reach the generator.
  assign zz_ext = {16'b0, s1_zz_r} * {25'b0, ZZ_MUL};
  assign zz_fix = s1_zz_r[31] ? {ZZ_MUL[15:0], 32'b0} : 48'd0;
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_xxk_r <= s1_xx_r * XX_MUL;
      s2_zzk_r <= zz_ext - zz_fix;
      s2_xt_r  <= s1_xt_r;
      s2_zt_r  <= s1_zt_r;
    end
  end

  // Stage 3: pairwise sums of the sign-extended terms.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sa_r <= {{16{s2_xxk_r[31]}}, s2_xxk_r} + {{16{s2_xt_r[31]}}, s2_xt_r};
      s3_sb_r <= s2_zzk_r + {{16{s2_zt_r[31]}}, s2_zt_r};
    end
  end

  // Stage 4: add the world seed, mix, and scramble into the generator state.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_st_r <= (world_seed_r[47:0] + s3_sa_r + s3_sb_r) ^ CHUNK_XOR ^ LCG_MUL;
    end
  end

  // Stage 5: partial products of the first generator step.
  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_pp_r <= lcg_pp(s4_st_r);
    end
  end

  // Stage 6: sum of the partial products gives the first drawn state.
  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_st_r <= lcg_sum(s5_pp_r);
    end
  end

  // Stage 7: draw check, redrawing where the draw is out of range.
  scc_redraw u_redraw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s6_v_r),
    .in_ready  (rd_in_ready),
    .in_state  (s6_st_r),
    .out_valid (rd_out_valid),
    .out_ready (rdy8),
    .out_draw  (rd_draw),
    .stat      (rd_stat)
  );

  // Stage 8: multiply by the reciprocal of ten.
  always_ff @(posedge clk) begin
    if (rdy8) begin
      s8_draw_r <= rd_draw;
      s8_prod_r <= {32'b0, rd_draw} * {31'b0, RECIP10};
    end
  end

  // Stage 9: the draw is a multiple of ten when quotient times ten gives it back.
  assign s9_q   = s8_prod_r[62:RECIP10_SH];
  assign s9_q10 = {s9_q, 3'b0} + {2'b0, s9_q, 1'b0};
  always_ff @(posedge clk) begin
    if (rdy9) begin
      out_flag_r <= (s9_q10 == s8_draw_r);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_flag_r};

  // Checks.
  `SCC_ASSERT_RST(a_out_empty_after_reset, clk, !rst_n |=> !out_tvalid,
                  "result valid straight after reset")
  `SCC_ASSERT(a_draw_in_range, clk, rst_n, s8_v_r |-> (s8_draw_r < DRAW_LIMIT),
              "rejected draw passed the redraw unit")
  `SCC_ASSERT(a_rem_below_ten, clk, rst_n, s8_v_r |-> ((s8_draw_r - s9_q10) < 31'd10),
              "reciprocal division gave a wrong quotient")
  `SCC_ASSERT(a_redraw_holds, clk, rst_n, rd_stat.busy |-> !rd_out_valid,
              "redraw unit released an item while stepping it")
  `SCC_ASSERT(a_add_follows_mul, clk, rst_n, $rose(rd_stat.add_ph) |-> $past(rd_stat.busy),
              "redraw summing phase without a rejected draw")

endmodule

`default_nettype wire
